@@ hdl/crm_pkg.sv @@
`default_nettype none
package crm_pkg;

    // rule modes
    localparam logic [2:0] MODE_NONE    = 3'd0;
    localparam logic [2:0] MODE_DAILY   = 3'd1;
    localparam logic [2:0] MODE_WEEKLY  = 3'd2;
    localparam logic [2:0] MODE_MPOS    = 3'd3;
    localparam logic [2:0] MODE_MDAY    = 3'd4;
    localparam logic [2:0] MODE_YMONTH  = 3'd5;
    localparam logic [2:0] MODE_YDAY    = 3'd6;

    // window bounds
    localparam logic [1:0] LIMIT_ENDLESS  = 2'd0;
    localparam logic [1:0] LIMIT_COUNT    = 2'd1;
    localparam logic [1:0] LIMIT_END_DATE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_RULE_MODE       = 3'd0;
    localparam logic [2:0] REG_PERIOD_MULTIPLE = 3'd1;
    localparam logic [2:0] REG_LIMIT_KIND      = 3'd2;
    localparam logic [2:0] REG_COUNT_SPAN      = 3'd3;
    localparam logic [2:0] REG_START_DATE      = 3'd4;
    localparam logic [2:0] REG_END_DATE        = 3'd5;
    localparam logic [2:0] REG_DAY_PATTERN     = 3'd6;
    localparam logic [2:0] REG_ENTRY_LIST      = 3'd7;

    // floor(x/100) = (x*5243)>>19 for x < 43690
    localparam logic [12:0] DIV100_MUL = 13'd5243;
    // floor(x/7) = (x*9586981)>>26 for x < 2^23
    localparam logic [23:0] DIV7_MUL   = 24'd9586981;
    localparam int          YEAR_BIAS  = 399;

    // steps of the remainder unit and stages of the date converter
    localparam int DIV_W       = 23;
    localparam int CONV_STAGES = 4;

    typedef struct packed {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        leap;
        logic [22:0] serial;
        logic [2:0]  weekday;
        logic [8:0]  yday;
        logic [4:0]  mdays;
    } civil_t;

    function automatic logic [8:0] month_base(input logic [3:0] m);
        logic [8:0] b;
        unique case (m)
            4'd1:    b = 9'd0;
            4'd2:    b = 9'd31;
            4'd3:    b = 9'd59;
            4'd4:    b = 9'd90;
            4'd5:    b = 9'd120;
            4'd6:    b = 9'd151;
            4'd7:    b = 9'd181;
            4'd8:    b = 9'd212;
            4'd9:    b = 9'd243;
            4'd10:   b = 9'd273;
            4'd11:   b = 9'd304;
            4'd12:   b = 9'd334;
            default: b = 9'd0;
        endcase
        return b;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] n;
        unique case (m)
            4'd2:                      n = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
            default:                   n = 5'd31;
        endcase
        return n;
    endfunction

    // floor(x/7) for a 5-bit value
    function automatic logic [2:0] div7_small(input logic [4:0] x);
        logic [2:0] q;
        priority if (x >= 5'd28) q = 3'd4;
        else if (x >= 5'd21)     q = 3'd3;
        else if (x >= 5'd14)     q = 3'd2;
        else if (x >= 5'd7)      q = 3'd1;
        else                     q = 3'd0;
        return q;
    endfunction

endpackage
`default_nettype wire

@@ hdl/calendar_recurrence_matcher.sv @@
`default_nettype none
// Recurrence-rule date matcher. Each request on the s_ channel carries one
// Gregorian date (year, month, day); the block answers with one m_occurs bit
// telling whether the configured rule (daily, weekly mask, monthly weekday
// position, monthly day number from start or end, yearly month, yearly day of
// year) produces an occurrence on that date, inside the window opened by
// start_date and closed by a count, an end date or nothing. One request is
// taken per clock unless a full pipeline waits on m_ready. Date converters,
// offsets, bound multiply, week split, pattern match, a period remainder of
// one dividend bit per stage and the output register make up the pipeline.
// Each stage holds on its own, so bubbles fill while a result waits on
// m_ready. Registers sit on a 64-bit APB port at byte address 8*index:
// rule_mode, period_multiple, limit_kind, count_span, start_date, end_date,
// day_pattern, entry_list. Write them only while no request is in flight.
module calendar_recurrence_matcher
    import crm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // query requests
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [13:0] s_query_year,
    input  wire logic [3:0]  s_query_month,
    input  wire logic [4:0]  s_query_day,
    // results
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_occurs,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int NSTG   = CONV_STAGES + 4 + DIV_W + 1;
    localparam int ST_P5  = CONV_STAGES + 1;
    localparam int ST_P6  = CONV_STAGES + 2;
    localparam int ST_P7  = CONV_STAGES + 3;
    localparam int ST_P8  = CONV_STAGES + 4;
    localparam int ST_MOD = CONV_STAGES + 5;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [2:0]  rule_mode_reg;
    logic [11:0] period_multiple_reg;
    logic [1:0]  limit_kind_reg;
    logic [15:0] count_span_reg;
    logic [22:0] start_date_reg;
    logic [22:0] end_date_reg;
    logic [61:0] day_pattern_reg;
    logic [59:0] entry_list_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rule_mode_reg       <= MODE_NONE;
            period_multiple_reg <= 12'd1;
            limit_kind_reg      <= LIMIT_ENDLESS;
            count_span_reg      <= 16'd0;
            start_date_reg      <= 23'd545;
            end_date_reg        <= 23'd545;
            day_pattern_reg     <= 62'd0;
            entry_list_reg      <= 60'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_RULE_MODE:       rule_mode_reg       <= pwdata[2:0];
                REG_PERIOD_MULTIPLE: period_multiple_reg <= pwdata[11:0];
                REG_LIMIT_KIND:      limit_kind_reg      <= pwdata[1:0];
                REG_COUNT_SPAN:      count_span_reg      <= pwdata[15:0];
                REG_START_DATE:      start_date_reg      <= pwdata[22:0];
                REG_END_DATE:        end_date_reg        <= pwdata[22:0];
                REG_DAY_PATTERN:     day_pattern_reg     <= pwdata[61:0];
                REG_ENTRY_LIST:      entry_list_reg      <= pwdata[59:0];
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_RULE_MODE:       prdata = 64'(rule_mode_reg);
            REG_PERIOD_MULTIPLE: prdata = 64'(period_multiple_reg);
            REG_LIMIT_KIND:      prdata = 64'(limit_kind_reg);
            REG_COUNT_SPAN:      prdata = 64'(count_span_reg);
            REG_START_DATE:      prdata = 64'(start_date_reg);
            REG_END_DATE:        prdata = 64'(end_date_reg);
            REG_DAY_PATTERN:     prdata = 64'(day_pattern_reg);
            REG_ENTRY_LIST:      prdata = 64'(entry_list_reg);
        endcase
    end

    // ---------------------------------------------------------------
    // Stage flow: a stage loads when it is empty or some later stage
    // frees a slot, so hold only what cannot move.
    // ---------------------------------------------------------------
    logic [NSTG:1] v_reg;
    logic [NSTG:1] v_next;
    logic [NSTG:1] en;

    for (genvar k = 1; k <= NSTG; k++) begin : g_en
        assign en[k] = m_ready || !(&v_reg[NSTG:k]);
    end

    always_comb begin
        v_next[1] = en[1] ? s_valid : v_reg[1];
        for (int k = 2; k <= NSTG; k++) begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    assign s_ready = en[1];
    assign m_valid = v_reg[NSTG];

    // ---------------------------------------------------------------
    // Stages 1-4: convert query, start and end dates in parallel
    // ---------------------------------------------------------------
    civil_t q_civ;
    civil_t s_civ;
    civil_t e_civ;

    crm_date_conv u_conv_query (
        .aclk     (aclk),
        .stage_en (en[CONV_STAGES:1]),
        .year_i   (s_query_year),
        .month_i  (s_query_month),
        .day_i    (s_query_day),
        .date_o   (q_civ)
    );

    crm_date_conv u_conv_start (
        .aclk     (aclk),
        .stage_en (en[CONV_STAGES:1]),
        .year_i   (start_date_reg[22:9]),
        .month_i  (start_date_reg[8:5]),
        .day_i    (start_date_reg[4:0]),
        .date_o   (s_civ)
    );

    crm_date_conv u_conv_end (
        .aclk     (aclk),
        .stage_en (en[CONV_STAGES:1]),
        .year_i   (end_date_reg[22:9]),
        .month_i  (end_date_reg[8:5]),
        .day_i    (end_date_reg[4:0]),
        .date_o   (e_civ)
    );

    // ---------------------------------------------------------------
    // Stage 5: offsets against the start, end-date check, bound term
    // ---------------------------------------------------------------
    logic signed [14:0] years_s;
    logic signed [4:0]  mdiff_s;
    logic signed [19:0] months_s;
    logic [18:0]        span_x;
    logic [18:0]        bterm;

    logic [23:0]        days5_reg;
    logic               before5_reg;
    logic               endok5_reg;
    logic signed [19:0] months5_reg;
    logic signed [14:0] years5_reg;
    logic [18:0]        bterm5_reg;
    logic [11:0]        freq5_reg;
    civil_t             q5_reg;
    logic               sleap5_reg;
    logic [4:0]         sday5_reg;

    always_comb begin
        years_s  = $signed({1'b0, q_civ.year} - {1'b0, s_civ.year});
        mdiff_s  = $signed({1'b0, q_civ.month} - {1'b0, s_civ.month});
        months_s = (20'(years_s) <<< 3) + (20'(years_s) <<< 2) + 20'(mdiff_s);
        span_x   = {3'd0, count_span_reg};
        // weekly bound counts whole weeks plus the rest of the start week
        if (rule_mode_reg == MODE_WEEKLY) begin
            bterm = (span_x << 3) - span_x + {16'd0, 3'd7 - s_civ.weekday};
        end else begin
            bterm = span_x;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_P5]) begin
            days5_reg   <= {1'b0, q_civ.serial} - {1'b0, s_civ.serial};
            before5_reg <= (q_civ.serial < s_civ.serial);
            endok5_reg  <= (q_civ.serial <= e_civ.serial);
            months5_reg <= months_s;
            years5_reg  <= years_s;
            bterm5_reg  <= bterm;
            freq5_reg   <= (period_multiple_reg == 12'd0) ? 12'd1 : period_multiple_reg;
            q5_reg      <= q_civ;
            sleap5_reg  <= s_civ.leap;
            sday5_reg   <= s_civ.day;
        end
    end

    // ---------------------------------------------------------------
    // Stage 6: count bound = bound term * period
    // ---------------------------------------------------------------
    logic [30:0]        bound6_reg;
    logic [23:0]        days6_reg;
    logic               before6_reg;
    logic               endok6_reg;
    logic signed [19:0] months6_reg;
    logic signed [14:0] years6_reg;
    logic [11:0]        freq6_reg;
    civil_t             q6_reg;
    logic               sleap6_reg;
    logic [4:0]         sday6_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_P6]) begin
            bound6_reg  <= {12'd0, bterm5_reg} * {19'd0, freq5_reg};
            days6_reg   <= days5_reg;
            before6_reg <= before5_reg;
            endok6_reg  <= endok5_reg;
            months6_reg <= months5_reg;
            years6_reg  <= years5_reg;
            freq6_reg   <= freq5_reg;
            q6_reg      <= q5_reg;
            sleap6_reg  <= sleap5_reg;
            sday6_reg   <= sday5_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: week number of the day offset
    // ---------------------------------------------------------------
    logic [46:0]        wprod;
    logic [20:0]        weeks7_reg;
    logic [30:0]        bound7_reg;
    logic [23:0]        days7_reg;
    logic               before7_reg;
    logic               endok7_reg;
    logic signed [19:0] months7_reg;
    logic signed [14:0] years7_reg;
    logic [11:0]        freq7_reg;
    civil_t             q7_reg;
    logic               sleap7_reg;
    logic [4:0]         sday7_reg;

    assign wprod = {24'd0, days6_reg[22:0]} * {23'd0, DIV7_MUL};

    always_ff @(posedge aclk) begin
        if (en[ST_P7]) begin
            weeks7_reg  <= wprod[46:26];
            bound7_reg  <= bound6_reg;
            days7_reg   <= days6_reg;
            before7_reg <= before6_reg;
            endok7_reg  <= endok6_reg;
            months7_reg <= months6_reg;
            years7_reg  <= years6_reg;
            freq7_reg   <= freq6_reg;
            q7_reg      <= q6_reg;
            sleap7_reg  <= sleap6_reg;
            sday7_reg   <= sday6_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stage 8: window, pattern match, pick the period dividend
    // ---------------------------------------------------------------
    logic [22:0]        offset;
    logic [22:0]        dividend;
    logic               neg_off;
    logic               limit_ok;
    logic               window_ok;
    logic               hit;
    logic [2:0]         wd_idx;
    logic [6:0]         wk_mask;
    logic               day_ok;
    logic [2:0]         fwd_pos;
    logic [2:0]         back_pos;
    logic               pos_hit;
    logic [11:0]        pos_ent;
    logic [6:0]         pos_mask;
    logic [2:0]         want_pos;
    logic [30:0]        fwd_days;
    logic [30:0]        end_days;
    logic [4:0]         end_idx;
    logic [11:0]        month_mask;
    logic signed [10:0] yidx;
    logic [9:0]         yent;
    logic               yday_hit;

    logic               tag8_reg;
    logic [22:0]        dvd8_reg;
    logic [11:0]        freq8_reg;

    always_comb begin
        wd_idx     = q7_reg.weekday - 3'd1;
        wk_mask    = day_pattern_reg[6:0];
        fwd_days   = day_pattern_reg[30:0];
        end_days   = day_pattern_reg[61:31];
        month_mask = day_pattern_reg[11:0];
        day_ok     = (q7_reg.day >= 5'd1) && (q7_reg.day <= q7_reg.mdays);
        fwd_pos    = div7_small(q7_reg.day - 5'd1) + 3'd1;
        back_pos   = div7_small(q7_reg.mdays - q7_reg.day) + 3'd1;
        end_idx    = q7_reg.mdays - q7_reg.day;

        // test every position entry on its own
        pos_hit = 1'b0;
        for (int k = 0; k < 5; k++) begin
            pos_ent  = entry_list_reg[12*k +: 12];
            pos_mask = pos_ent[6:0];
            want_pos = pos_ent[10] ? back_pos : fwd_pos;
            pos_hit  = pos_hit || (pos_ent[11] && (pos_ent[9:7] == want_pos)
                                   && pos_mask[wd_idx]);
        end

        // shift day of year past February when start and query leap differ
        yidx = $signed({2'b00, q7_reg.yday});
        if (q7_reg.yday > 9'd59) begin
            if (!sleap7_reg && q7_reg.leap) begin
                yidx = yidx - 11'sd1;
            end else if (sleap7_reg && !q7_reg.leap) begin
                yidx = yidx + 11'sd1;
            end
        end
        yday_hit = 1'b0;
        for (int k = 0; k < 6; k++) begin
            yent     = entry_list_reg[10*k +: 10];
            yday_hit = yday_hit || ((yent != 10'd0) && ($signed({1'b0, yent}) == yidx));
        end

        offset   = 23'd0;
        dividend = 23'd0;
        neg_off  = 1'b0;
        hit      = 1'b0;
        unique case (rule_mode_reg)
            MODE_DAILY: begin
                offset   = days7_reg[22:0];
                dividend = days7_reg[22:0];
                hit      = 1'b1;
            end
            MODE_WEEKLY: begin
                offset   = days7_reg[22:0];
                dividend = {2'd0, weeks7_reg};
                hit      = wk_mask[wd_idx];
            end
            MODE_MPOS: begin
                offset   = {5'd0, months7_reg[17:0]};
                dividend = {5'd0, months7_reg[17:0]};
                neg_off  = months7_reg[19];
                hit      = day_ok && pos_hit;
            end
            MODE_MDAY: begin
                offset   = {5'd0, months7_reg[17:0]};
                dividend = {5'd0, months7_reg[17:0]};
                neg_off  = months7_reg[19];
                hit      = day_ok && (fwd_days[q7_reg.day - 5'd1] || end_days[end_idx]);
            end
            MODE_YMONTH: begin
                offset   = {9'd0, years7_reg[13:0]};
                dividend = {9'd0, years7_reg[13:0]};
                neg_off  = years7_reg[14];
                hit      = month_mask[q7_reg.month - 4'd1] && (q7_reg.day == sday7_reg);
            end
            MODE_YDAY: begin
                offset   = {9'd0, years7_reg[13:0]};
                dividend = {9'd0, years7_reg[13:0]};
                neg_off  = years7_reg[14];
                hit      = yday_hit;
            end
            default: begin
                hit = 1'b0;
            end
        endcase

        unique case (limit_kind_reg)
            LIMIT_ENDLESS:  limit_ok = 1'b1;
            LIMIT_COUNT:    limit_ok = ({8'd0, offset} <= bound7_reg);
            LIMIT_END_DATE: limit_ok = endok7_reg;
            default:        limit_ok = 1'b0;
        endcase

        window_ok = !before7_reg && !neg_off && limit_ok;
    end

    always_ff @(posedge aclk) begin
        if (en[ST_P8]) begin
            tag8_reg  <= window_ok && hit;
            dvd8_reg  <= dividend;
            freq8_reg <= freq7_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stages 9-31: offset modulo period; drop the hit on a nonzero rest
    // ---------------------------------------------------------------
    logic mod_rem_zero;
    logic mod_tag;

    crm_mod_pipe u_mod (
        .aclk       (aclk),
        .stage_en   (en[ST_MOD+DIV_W-1:ST_MOD]),
        .dividend_i (dvd8_reg),
        .divisor_i  (freq8_reg),
        .tag_i      (tag8_reg),
        .rem_zero_o (mod_rem_zero),
        .tag_o      (mod_tag)
    );

    // ---------------------------------------------------------------
    // Stage 32: output register, hold until the request is taken
    // ---------------------------------------------------------------
    logic occurs_reg;

    always_ff @(posedge aclk) begin
        if (en[NSTG]) begin
            occurs_reg <= mod_tag && mod_rem_zero;
        end
    end

    assign m_occurs = occurs_reg;

endmodule
`default_nettype wire

@@ hdl/crm_date_conv.sv @@
`default_nettype none
// Four-stage Gregorian date converter: leap flag, day of year, day serial, weekday.
module crm_date_conv
    import crm_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic [CONV_STAGES-1:0] stage_en,
    input  wire logic [13:0]            year_i,
    input  wire logic [3:0]             month_i,
    input  wire logic [4:0]             day_i,
    output civil_t                      date_o
);

    // stage 1: clamp month, year/100
    logic [3:0]  m_clamp;
    logic [26:0] yprod;
    logic [13:0] y1_reg;
    logic [3:0]  m1_reg;
    logic [4:0]  d1_reg;
    logic [7:0]  yq1_reg;

    assign m_clamp = (month_i < 4'd1) ? 4'd1 : ((month_i > 4'd12) ? 4'd12 : month_i);
    assign yprod   = {13'd0, year_i} * {14'd0, DIV100_MUL};

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            y1_reg  <= year_i;
            m1_reg  <= m_clamp;
            d1_reg  <= day_i;
            yq1_reg <= yprod[26:19];
        end
    end

    // stage 2: leap flag, day of year, month length, biased year/100
    logic [14:0] sy1;
    logic [27:0] syprod;
    logic [13:0] yq_x100;
    logic        leap1;
    logic [8:0]  yday1;
    logic [4:0]  mdays1;
    logic [13:0] y2_reg;
    logic [3:0]  m2_reg;
    logic [4:0]  d2_reg;
    logic        leap2_reg;
    logic [14:0] sy2_reg;
    logic [7:0]  syq2_reg;
    logic [8:0]  yday2_reg;
    logic [4:0]  mdays2_reg;

    assign sy1     = {1'b0, y1_reg} + 15'(YEAR_BIAS);
    assign syprod  = {13'd0, sy1} * {15'd0, DIV100_MUL};
    assign yq_x100 = {6'd0, yq1_reg} * 14'd100;
    assign leap1   = (y1_reg[1:0] == 2'd0) && ((y1_reg != yq_x100) || (yq1_reg[1:0] == 2'd0));
    assign yday1   = month_base(m1_reg) + {8'd0, leap1 && (m1_reg > 4'd2)} + {4'd0, d1_reg};
    assign mdays1  = month_len(m1_reg) + {4'd0, leap1 && (m1_reg == 4'd2)};

    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            y2_reg     <= y1_reg;
            m2_reg     <= m1_reg;
            d2_reg     <= d1_reg;
            leap2_reg  <= leap1;
            sy2_reg    <= sy1;
            syq2_reg   <= syprod[26:19];
            yday2_reg  <= yday1;
            mdays2_reg <= mdays1;
        end
    end

    // stage 3: day serial
    logic [23:0] serial_sum;
    civil_t      d3_reg;

    assign serial_sum = {9'd0, sy2_reg} * 24'd365 + {11'd0, sy2_reg[14:2]}
                      - {16'd0, syq2_reg} + {18'd0, syq2_reg[7:2]}
                      + {15'd0, yday2_reg} - 24'd1;

    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            d3_reg.year    <= y2_reg;
            d3_reg.month   <= m2_reg;
            d3_reg.day     <= d2_reg;
            d3_reg.leap    <= leap2_reg;
            d3_reg.serial  <= serial_sum[22:0];
            d3_reg.weekday <= 3'd0;
            d3_reg.yday    <= yday2_reg;
            d3_reg.mdays   <= mdays2_reg;
        end
    end

    // stage 4: weekday; 8 = 1 mod 7, so fold octal digits
    logic [23:0] ser_pad;
    logic [5:0]  fold1;
    logic [3:0]  fold2;
    logic [2:0]  wd_mod;
    civil_t      date_next;
    civil_t      date_reg;

    always_comb begin
        ser_pad = {1'b0, d3_reg.serial};
        fold1   = 6'd0;
        for (int g = 0; g < 8; g++) begin
            fold1 = fold1 + {3'd0, ser_pad[3*g +: 3]};
        end
        fold2  = {1'b0, fold1[2:0]} + {1'b0, fold1[5:3]};
        wd_mod = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];
        date_next         = d3_reg;
        date_next.weekday = wd_mod + 3'd1;
    end

    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            date_reg <= date_next;
        end
    end

    assign date_o = date_reg;

endmodule
`default_nettype wire

@@ hdl/crm_mod_pipe.sv @@
`default_nettype none
// Restoring remainder, one dividend bit per stage; tag rides along.
module crm_mod_pipe
    import crm_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic [DIV_W-1:0] stage_en,
    input  wire logic [DIV_W-1:0] dividend_i,
    input  wire logic [11:0]      divisor_i,
    input  wire logic             tag_i,
    output logic                  rem_zero_o,
    output logic                  tag_o
);

    logic [11:0]      rem_reg [DIV_W];
    logic [DIV_W-1:0] dvd_reg [DIV_W];
    logic [11:0]      div_reg [DIV_W];
    logic             tag_reg [DIV_W];

    logic [11:0]      src_rem [DIV_W];
    logic [DIV_W-1:0] src_dvd [DIV_W];
    logic [11:0]      src_div [DIV_W];
    logic             src_tag [DIV_W];
    logic [12:0]      trial   [DIV_W];
    logic [11:0]      rem_nxt [DIV_W];

    always_comb begin
        src_rem[0] = 12'd0;
        src_dvd[0] = dividend_i;
        src_div[0] = divisor_i;
        src_tag[0] = tag_i;
        for (int j = 1; j < DIV_W; j++) begin
            src_rem[j] = rem_reg[j-1];
            src_dvd[j] = dvd_reg[j-1];
            src_div[j] = div_reg[j-1];
            src_tag[j] = tag_reg[j-1];
        end
        for (int j = 0; j < DIV_W; j++) begin
            trial[j]   = {src_rem[j], src_dvd[j][DIV_W-1-j]};
            rem_nxt[j] = (trial[j] >= {1'b0, src_div[j]}) ?
                         12'(trial[j] - {1'b0, src_div[j]}) : trial[j][11:0];
        end
    end

    always_ff @(posedge aclk) begin
        for (int j = 0; j < DIV_W; j++) begin
            if (stage_en[j]) begin
                rem_reg[j] <= rem_nxt[j];
                dvd_reg[j] <= src_dvd[j];
                div_reg[j] <= src_div[j];
                tag_reg[j] <= src_tag[j];
            end
        end
    end

    assign rem_zero_o = (rem_reg[DIV_W-1] == 12'd0);
    assign tag_o      = tag_reg[DIV_W-1];

endmodule
`default_nettype wire

@@ hdl/crm_checker.sv @@
`default_nettype none
module crm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_occurs,
    input wire logic        pready
);

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_occurs))
        else $error("result changed while stalled");

    // with the output free, a request is always taken
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled with free output");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // no result appears in the first cycle after reset
    a_no_early: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result right after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind calendar_recurrence_matcher crm_checker u_crm_checker (.*);
`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
    import crm_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [13:0] s_query_year;
    logic [3:0]  s_query_month;
    logic [4:0]  s_query_day;
    logic        m_valid;
    logic        m_ready;
    logic        m_occurs;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    calendar_recurrence_matcher dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_query_year(s_query_year),
        .s_query_month(s_query_month), .s_query_day(s_query_day),
        .m_valid(m_valid), .m_ready(m_ready), .m_occurs(m_occurs),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    localparam int LATENCY = 32;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic [2:0] MODE_UNDEFINED  = 3'd7;
    localparam logic [1:0] LIMIT_UNDEFINED = 2'd3;

    // shadow copy of the rule registers
    logic [2:0]  cfg_mode;
    logic [11:0] cfg_period;
    logic [1:0]  cfg_limit;
    logic [15:0] cfg_span;
    logic [22:0] cfg_start;
    logic [22:0] cfg_end;
    logic [61:0] cfg_pattern;
    logic [59:0] cfg_entries;

    bit     occurs_due[$];
    int     errors;
    longint cycle_cnt;
    bit     hold_off;
    bit     press_go;

    typedef struct {
        longint year;
        int     month;
        int     day;
        bit     leap;
        longint serial;
        int     weekday;
        int     yday;
        int     mdays;
    } date_info_t;

    typedef struct {
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        bit          has_exp;
        bit          exp_occurs;
    } query_row_t;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) cycle_cnt <= cycle_cnt + 1;

    function automatic bit leap_year(longint y);
        return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function automatic date_info_t to_date(longint y, int m, int d);
        date_info_t c;
        longint sy;
        int base[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        int len[13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
        c.year = y;
        c.month = (m < 1) ? 1 : ((m > 12) ? 12 : m);
        c.day = d;
        c.leap = leap_year(y);
        sy = y + 399;
        c.yday = base[c.month] + ((c.leap && c.month > 2) ? 1 : 0) + d;
        c.serial = 365 * sy + sy / 4 - sy / 100 + sy / 400 + c.yday - 1;
        c.weekday = int'(c.serial % 7) + 1;
        c.mdays = len[c.month] + ((c.leap && c.month == 2) ? 1 : 0);
        return c;
    endfunction

    function automatic date_info_t from_packed(logic [22:0] v);
        return to_date(longint'(v[22:9]), int'(v[8:5]), int'(v[4:0]));
    endfunction

    function automatic bit within_bounds(date_info_t q, date_info_t s, longint off,
                                         longint bound);
        date_info_t e;
        if (q.serial < s.serial) return 1'b0;
        case (cfg_limit)
            LIMIT_ENDLESS: return 1'b1;
            LIMIT_COUNT:   return off <= bound;
            LIMIT_END_DATE: begin
                e = from_packed(cfg_end);
                return q.serial <= e.serial;
            end
            default:       return 1'b0;
        endcase
    endfunction

    // work out whether the current rule hits the queried date
    function automatic bit rule_occurs(logic [13:0] y, logic [3:0] m, logic [4:0] d);
        date_info_t q, s, feb;
        longint freq, span, days, months, years, idx, ent, bound;
        int fwd, back, pos, want;
        bit hit;
        q = to_date(longint'(y), int'(m), int'(d));
        s = from_packed(cfg_start);
        freq = (cfg_period == 0) ? 1 : longint'(cfg_period);
        span = longint'(cfg_span);
        days = q.serial - s.serial;
        months = (q.year - s.year) * 12 + (q.month - s.month);
        years = q.year - s.year;
        hit = 1'b0;
        case (cfg_mode)
            MODE_DAILY: begin
                if (within_bounds(q, s, days, span * freq)) hit = (days % freq) == 0;
            end
            MODE_WEEKLY: begin
                bound = (span * 7 + (7 - s.weekday)) * freq;
                if (within_bounds(q, s, days, bound) && ((days / 7) % freq) == 0)
                    hit = cfg_pattern[q.weekday - 1];
            end
            MODE_MPOS: begin
                if (months >= 0 && within_bounds(q, s, months, span * freq)
                        && (months % freq) == 0 && q.day >= 1 && q.day <= q.mdays) begin
                    fwd = (q.day - 1) / 7 + 1;
                    back = (q.mdays - q.day) / 7 + 1;
                    for (int k = 0; k < 5; k++) begin
                        ent = longint'(cfg_entries[12 * k +: 12]);
                        pos = int'((ent >> 7) & 7);
                        want = ent[10] ? back : fwd;
                        if (ent[11] && pos == want && ent[q.weekday - 1]) hit = 1'b1;
                    end
                end
            end
            MODE_MDAY: begin
                if (months >= 0 && within_bounds(q, s, months, span * freq)
                        && (months % freq) == 0 && q.day >= 1 && q.day <= q.mdays)
                    hit = cfg_pattern[q.day - 1] || cfg_pattern[31 + q.mdays - q.day];
            end
            MODE_YMONTH: begin
                if (years >= 0 && within_bounds(q, s, years, span * freq)
                        && (years % freq) == 0)
                    hit = cfg_pattern[q.month - 1] && q.day == s.day;
            end
            MODE_YDAY: begin
                feb = to_date(q.year, 2, 28);
                if (years >= 0 && within_bounds(q, s, years, span * freq)
                        && (years % freq) == 0) begin
                    idx = q.yday;
                    // shift past Feb 28 when the start and query years differ in leap
                    if (q.serial > feb.serial) begin
                        if (!s.leap && q.leap) idx--;
                        else if (s.leap && !q.leap) idx++;
                    end
                    for (int k = 0; k < 6; k++) begin
                        ent = longint'(cfg_entries[10 * k +: 10]);
                        if (ent != 0 && ent == idx) hit = 1'b1;
                    end
                end
            end
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_cnt, what);
        errors++;
    endtask

    // setup cycle, then access cycle; the write lands at the access edge
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RULE_MODE:       cfg_mode = value[2:0];
            REG_PERIOD_MULTIPLE: cfg_period = value[11:0];
            REG_LIMIT_KIND:      cfg_limit = value[1:0];
            REG_COUNT_SPAN:      cfg_span = value[15:0];
            REG_START_DATE:      cfg_start = value[22:0];
            REG_END_DATE:        cfg_end = value[22:0];
            REG_DAY_PATTERN:     cfg_pattern = value[61:0];
            default:             cfg_entries = value[59:0];
        endcase
    endtask

    task automatic write_rule(logic [2:0] mode, logic [11:0] period, logic [1:0] lim,
                              logic [15:0] span, logic [22:0] sd, logic [22:0] ed,
                              logic [61:0] pat, logic [59:0] ents);
        write_reg(REG_RULE_MODE, 64'(mode));
        write_reg(REG_PERIOD_MULTIPLE, 64'(period));
        write_reg(REG_LIMIT_KIND, 64'(lim));
        write_reg(REG_COUNT_SPAN, 64'(span));
        write_reg(REG_START_DATE, 64'(sd));
        write_reg(REG_END_DATE, 64'(ed));
        write_reg(REG_DAY_PATTERN, 64'(pat));
        write_reg(REG_ENTRY_LIST, 64'(ents));
    endtask

    // offer one request and hold it until accepted; predict on acceptance
    task automatic send_query(logic [13:0] y, logic [3:0] m, logic [4:0] d);
        s_valid <= 1'b1;
        s_query_year <= y;
        s_query_month <= m;
        s_query_day <= d;
        do @(posedge aclk); while (!s_ready);
        occurs_due.push_back(rule_occurs(y, m, d));
    endtask

    task automatic idle_sender(int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // drain: wait for every predicted result, then let the pipeline settle
    task automatic drain;
        s_valid <= 1'b0;
        while (occurs_due.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [22:0] pack_date(int y, int m, int d);
        return {14'(y), 4'(m), 5'(d)};
    endfunction

    // random date, mostly near the start year, sometimes anywhere
    task automatic random_query(int base_year);
        int y;
        if ($urandom_range(0, 9) == 0) y = $urandom_range(0, 16383);
        else y = base_year + $urandom_range(0, 12);
        if (y > 16383) y = 16383;
        if ($urandom_range(0, 19) == 0)
            send_query(14'(y), 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
        else
            send_query(14'(y), 4'($urandom_range(1, 12)), 5'($urandom_range(1, 31)));
    endtask

    // result side: stall on a pattern, with one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (occurs_due.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else if (m_occurs !== occurs_due[0]) begin
                    report_mismatch($sformatf("occurs %b, expected %b", m_occurs,
                                              occurs_due[0]));
                    void'(occurs_due.pop_front());
                end else begin
                    void'(occurs_due.pop_front());
                end
            end
            if (hold_off) m_ready <= 1'b0;
            else m_ready <= (cycle_cnt % 64 < 40) ? 1'b1 : ($urandom_range(0, 2) != 0);
        end
    end

    // hold off the result side while the sender keeps offering requests
    initial begin
        hold_off = 1'b0;
        wait (press_go);
        hold_off = 1'b1;
        repeat (200) @(posedge aclk);
        hold_off = 1'b0;
    end

    initial begin
        wait (cycle_cnt == CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    query_row_t rows[$];
    int         burst;
    int         sy;

    initial begin
        cycle_cnt = 0;
        errors = 0;
        press_go = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_query_year = '0;
        s_query_month = '0;
        s_query_day = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_mode = MODE_NONE;
        cfg_period = 12'd1;
        cfg_limit = LIMIT_ENDLESS;
        cfg_span = '0;
        cfg_start = 23'd545;
        cfg_end = 23'd545;
        cfg_pattern = '0;
        cfg_entries = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // after reset the rule is none: nothing occurs, whatever the date
        rows = '{
            '{14'd1, 4'd1, 5'd1, 1'b1, 1'b0},
            '{14'h3FFF, 4'hF, 5'h1F, 1'b1, 1'b0},
            '{14'd0, 4'd0, 5'd0, 1'b1, 1'b0},
            '{14'd9999, 4'd12, 5'd31, 1'b1, 1'b0}
        };
        foreach (rows[i]) begin
            send_query(rows[i].year, rows[i].month, rows[i].day);
            if (rows[i].has_exp && occurs_due[$] != rows[i].exp_occurs)
                report_mismatch("predictor disagrees with directed row");
        end
        drain();

        // daily from 2000-01-01, endless, every day: extremes and early dates
        write_rule(MODE_DAILY, 12'd0, LIMIT_ENDLESS, 16'd0, pack_date(2000, 1, 1),
                   pack_date(2000, 1, 1), '0, '0);
        rows = '{
            '{14'd2000, 4'd1, 5'd1, 1'b1, 1'b1},
            '{14'd1999, 4'd12, 5'd31, 1'b1, 1'b0},
            '{14'h3FFF, 4'd12, 5'd31, 1'b1, 1'b1},
            '{14'd2000, 4'd0, 5'd0, 1'b1, 1'b0},
            '{14'd2000, 4'd15, 5'd31, 1'b0, 1'b0}
        };
        foreach (rows[i]) begin
            send_query(rows[i].year, rows[i].month, rows[i].day);
            if (rows[i].has_exp && occurs_due[$] != rows[i].exp_occurs)
                report_mismatch("predictor disagrees with directed row");
        end
        drain();

        // undefined mode and undefined limit: never occurs
        write_rule(MODE_UNDEFINED, 12'd1, LIMIT_ENDLESS, 16'd0, 23'd545, 23'd545, '1, '1);
        send_query(14'd2024, 4'd2, 5'd29);
        drain();
        write_reg(REG_RULE_MODE, 64'(MODE_DAILY));
        write_reg(REG_LIMIT_KIND, 64'(LIMIT_UNDEFINED));
        send_query(14'd2024, 4'd3, 5'd1);
        drain();

        // every mode once with full-scale registers, then once from a 2023-02-28 start
        for (int md = 1; md <= 6; md++) begin
            write_rule(3'(md), 12'hFFF, LIMIT_COUNT, 16'hFFFF, 23'h7FFFFF, 23'h7FFFFF,
                       '1, '1);
            send_query(14'h3FFF, 4'd12, 5'd31);
            drain();
            write_rule(3'(md), 12'd1, LIMIT_ENDLESS, 16'd0, pack_date(2023, 2, 28),
                       pack_date(9999, 12, 31), '1, {5{12'hFFF}});
            send_query(14'd2024, 4'd2, 5'd29);
            send_query(14'd2024, 4'd3, 5'd31);
            drain();
        end

        // random phases, each under a fresh rule
        for (int ph = 0; ph < 26; ph++) begin
            sy = $urandom_range(1, 9990);
            if (ph == 1) sy = 2000;
            write_rule(3'($urandom_range(1, 6)),
                       (ph % 5 == 0) ? 12'($urandom_range(0, 4095))
                                     : 12'($urandom_range(1, 4)),
                       2'($urandom_range(0, 2)),
                       (ph % 7 == 0) ? 16'($urandom_range(0, 65535))
                                     : 16'($urandom_range(0, 40)),
                       pack_date(sy, $urandom_range(0, 15), $urandom_range(0, 31)),
                       pack_date(sy + $urandom_range(0, 6), $urandom_range(1, 12),
                                 $urandom_range(1, 31)),
                       62'({$urandom, $urandom}), 60'({$urandom, $urandom}));
            if (ph == 3) press_go = 1'b1;
            for (int n = 0; n < 50; ) begin
                burst = $urandom_range(1, 12);
                for (int b = 0; b < burst && n < 50; b++, n++) random_query(sy);
                if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 5));
            end
            drain();
        end

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/crm_pkg.sv
hdl/crm_date_conv.sv
hdl/crm_mod_pipe.sv
hdl/calendar_recurrence_matcher.sv
hdl/crm_checker.sv
tb/sv/tb_top.sv
